// ===== src/ebalu_pkg.sv =====
package ebalu_pkg;

    typedef enum logic [3:0] {
        OP_INC   = 4'd0,
        OP_DEC   = 4'd1,
        OP_RLC   = 4'd2,
        OP_RRC   = 4'd3,
        OP_RL    = 4'd4,
        OP_RR    = 4'd5,
        OP_ADDHL = 4'd6,
        OP_ADDSP = 4'd7,
        OP_ADD   = 4'd8,
        OP_ADC   = 4'd9,
        OP_SUB   = 4'd10,
        OP_SBC   = 4'd11,
        OP_AND   = 4'd12,
        OP_XOR   = 4'd13,
        OP_OR    = 4'd14,
        OP_CP    = 4'd15
    } op_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        op_t         req_type;
        logic [7:0]  acc;
        logic [7:0]  operand8;
        logic [15:0] wide_base;
        logic [15:0] wide_addend;
        logic [3:0]  flags_in;
    } req_t;

    typedef struct packed {
        logic [7:0]  result8;
        logic [15:0] result16;
        logic [3:0]  flags_out;
    } rsp_t;

endpackage

// ===== src/ebalu_req_if.sv =====
interface ebalu_req_if;
    logic              valid;
    logic              ready;
    ebalu_pkg::req_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ebalu_rsp_if.sv =====
interface ebalu_rsp_if;
    logic              valid;
    logic              ready;
    ebalu_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ebalu_core.sv =====
module ebalu_core (
    input  ebalu_pkg::req_t req,
    output ebalu_pkg::rsp_t rsp
);

    always_comb
    begin
        logic [7:0]  a;
        logic [7:0]  x;
        logic        cin;
        logic        c;
        logic [7:0]  r8;
        logic [15:0] r16;
        logic [3:0]  f;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [15:0] ext;
        logic [8:0]  sum9;
        logic [4:0]  nib5;
        logic [8:0]  dif9;

        a     = req.acc;
        x     = req.operand8;
        cin   = req.flags_in[ebalu_pkg::FLAG_C];
        c     = 1'b0;
        r8    = 8'd0;
        r16   = 16'd0;
        f     = 4'd0;
        sum17 = 17'd0;
        sum13 = 13'd0;
        ext   = 16'd0;
        sum9  = 9'd0;
        nib5  = 5'd0;
        dif9  = 9'd0;

        case (req.req_type)
            ebalu_pkg::OP_INC:
            begin
                r8 = x + 8'd1;
                f[ebalu_pkg::FLAG_H] = (r8[3:0] == 4'h0);
                f[ebalu_pkg::FLAG_C] = cin;
            end
            ebalu_pkg::OP_DEC:
            begin
                r8 = x - 8'd1;
                f[ebalu_pkg::FLAG_N] = 1'b1;
                f[ebalu_pkg::FLAG_H] = (r8[3:0] == 4'hf);
                f[ebalu_pkg::FLAG_C] = cin;
            end
            ebalu_pkg::OP_RLC:
            begin
                r8 = {x[6:0], x[7]};
                f[ebalu_pkg::FLAG_C] = x[7];
            end
            ebalu_pkg::OP_RRC:
            begin
                r8 = {x[0], x[7:1]};
                f[ebalu_pkg::FLAG_C] = x[0];
            end
            ebalu_pkg::OP_RL:
            begin
                r8 = {x[6:0], cin};
                f[ebalu_pkg::FLAG_C] = x[7];
            end
            ebalu_pkg::OP_RR:
            begin
                r8 = {cin, x[7:1]};
                f[ebalu_pkg::FLAG_C] = x[0];
            end
            ebalu_pkg::OP_ADDHL:
            begin
                sum17 = {1'b0, req.wide_base} + {1'b0, req.wide_addend};
                sum13 = {1'b0, req.wide_base[11:0]} + {1'b0, req.wide_addend[11:0]};
                r16 = sum17[15:0];
                f[ebalu_pkg::FLAG_Z] = req.flags_in[ebalu_pkg::FLAG_Z];
                f[ebalu_pkg::FLAG_H] = sum13[12];
                f[ebalu_pkg::FLAG_C] = sum17[16];
            end
            ebalu_pkg::OP_ADDSP:
            begin
                ext  = {{8{x[7]}}, x};
                r16  = req.wide_base + ext;
                nib5 = {1'b0, req.wide_base[3:0]} + {1'b0, x[3:0]};
                sum9 = {1'b0, req.wide_base[7:0]} + {1'b0, x};
                f[ebalu_pkg::FLAG_H] = nib5[4];
                f[ebalu_pkg::FLAG_C] = sum9[8];
            end
            ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC:
            begin
                c    = (req.req_type == ebalu_pkg::OP_ADC) ? cin : 1'b0;
                sum9 = {1'b0, a} + {1'b0, x} + {8'd0, c};
                nib5 = {1'b0, a[3:0]} + {1'b0, x[3:0]} + {4'd0, c};
                r8   = sum9[7:0];
                f[ebalu_pkg::FLAG_H] = nib5[4];
                f[ebalu_pkg::FLAG_C] = sum9[8];
            end
            ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP:
            begin
                c    = (req.req_type == ebalu_pkg::OP_SBC) ? cin : 1'b0;
                dif9 = {1'b0, a} - {1'b0, x} - {8'd0, c};
                nib5 = {1'b0, a[3:0]} - {1'b0, x[3:0]} - {4'd0, c};
                r8   = (req.req_type == ebalu_pkg::OP_CP) ? a : dif9[7:0];
                f[ebalu_pkg::FLAG_N] = 1'b1;
                f[ebalu_pkg::FLAG_H] = nib5[4];
                f[ebalu_pkg::FLAG_C] = dif9[8];
            end
            ebalu_pkg::OP_AND:
            begin
                r8 = a & x;
                f[ebalu_pkg::FLAG_H] = 1'b1;
            end
            ebalu_pkg::OP_XOR:
            begin
                r8 = a ^ x;
            end
            default:
            begin
                r8 = a | x;
            end
        endcase

        // Z: sub-type ops test the difference, not the kept accumulator
        case (req.req_type)
            ebalu_pkg::OP_ADDHL, ebalu_pkg::OP_ADDSP:
            begin
            end
            ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP:
            begin
                f[ebalu_pkg::FLAG_Z] = (dif9[7:0] == 8'd0);
            end
            default:
            begin
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'd0);
            end
        endcase

        rsp.result8   = r8;
        rsp.result16  = r16;
        rsp.flags_out = f;
    end

endmodule

// ===== src/eight_bit_alu_with_flags_unit.sv =====
// Eight-bit ALU with Z/N/H/C flags.
// req channel: one item per operation (req_type, acc, operand8, wide_base,
// wide_addend, flags_in); rsp channel: one item back per request
// (result8, result16, flags_out), in request order.
// An item is taken when valid and ready are both high.
// The item is captured in an input register, evaluated by the flag/adder logic
// and captured in the result register, which drives rsp.valid.
// Throughput: one item per cycle while rsp.ready stays high, set by the single
// pass through the 16-bit adder and flag logic between the two registers.
// Reset clears both stage valid bits; no item is presented after reset
// until one is accepted.
// When the receiver stalls, the result register holds its item and the
// input register fills; req.ready drops only when both are occupied and
// rsp.ready is low.
module eight_bit_alu_with_flags_unit (
    input  logic        clk,
    input  logic        rst_n,
    ebalu_req_if.sink   req,
    ebalu_rsp_if.source rsp
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    ebalu_pkg::req_t s1_data_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    ebalu_pkg::rsp_t rsp_data_reg;
    ebalu_pkg::rsp_t core_rsp;
    logic            s2_take;
    logic            in_take;

    ebalu_core u_core (
        .req (s1_data_reg),
        .rsp (core_rsp)
    );

    always_comb
    begin
        s2_take        = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
        in_take        = req.valid && req.ready;
        s1_valid_next  = in_take || (s1_valid_reg && !s2_take);
        rsp_valid_next = s2_take || (rsp_valid_reg && !rsp.ready);
    end

    assign req.ready = !s1_valid_reg || s2_take;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= req.data;
        end
        if (s2_take)
        begin
            rsp_data_reg <= core_rsp;
        end
    end

    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req.ready
    ) else $error("req.ready low with empty input stage");

    a_stage_moves: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !rsp_valid_reg) |=> rsp_valid_reg
    ) else $error("input stage item did not reach result register");

    a_cp_keeps_acc: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_data_reg.req_type == ebalu_pkg::OP_CP)
            |-> (core_rsp.result8 == s1_data_reg.acc)
    ) else $error("cp altered the accumulator");

    a_narrow_no_wide: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_data_reg.req_type != ebalu_pkg::OP_ADDHL
            && s1_data_reg.req_type != ebalu_pkg::OP_ADDSP)
            |-> (core_rsp.result16 == 16'd0)
    ) else $error("8-bit operation drove result16");

endmodule
